// File: rtl/wpfm_pkg.sv
// ----------------------------------------------------------------------------
// wpfm_pkg
// Shared types and constants for the wildcard path filter matcher.
// ----------------------------------------------------------------------------
package wpfm_pkg;

	localparam logic [1:0] ACT_PAT  = 2'd0;
	localparam logic [1:0] ACT_NAME = 2'd1;
	localparam logic [1:0] ACT_EVAL = 2'd2;

	localparam int CFG_IW = 4;
	localparam logic [CFG_IW-1:0] REG_CASE_SENSITIVE = 4'd0;
	localparam logic [CFG_IW-1:0] REG_PATH_MODE      = 4'd1;

	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_LBR    = 8'h5B;
	localparam logic [7:0] CH_RBR    = 8'h5D;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LOW_A  = 8'h61;
	localparam logic [7:0] CH_LOW_Z  = 8'h7A;
	localparam logic [7:0] CASE_GAP  = 8'h20;

	typedef enum logic [1:0] {
		PA_P  = 2'd0,
		PA_P1 = 2'd1,
		PA_P2 = 2'd2,
		PA_SJ = 2'd3
	} pa_sel_t;

	typedef enum logic {
		NA_N  = 1'b0,
		NA_KJ = 1'b1
	} na_sel_t;

	typedef enum logic [1:0] {
		N_HOLD  = 2'd0,
		N_INC   = 2'd1,
		N_KRUN  = 2'd2,
		N_CLEAR = 2'd3
	} n_op_t;

	typedef struct packed {
		pa_sel_t    pa_sel;
		na_sel_t    na_sel;
		logic [1:0] p_inc;
		n_op_t      n_op;
		logic       init;
		logic       latch_c;
		logic       latch_a;
		logic       latch_b;
		logic       latch_nc;
		logic       clr_found;
		logic       fnd_single;
		logic       fnd_range;
		logic       start_set;
		logic       run_set;
		logic       k_set;
		logic       k_inc;
		logic       j_clr;
		logic       j_inc;
		logic       finish;
		logic       res;
	} wpfm_cmd_t;

	typedef struct packed {
		logic p_end;
		logic p1_ok;
		logic pd_star;
		logic pd_qmark;
		logic pd_lbr;
		logic pd_rbr;
		logic pd_dash;
		logic c_star;
		logic c_qmark;
		logic c_lbr;
		logic a_rbr;
		logic b_rbr;
		logic lit_eq;
		logic sj_eq;
		logic run_zero;
		logic run_over;
		logic k_over;
		logic j_done;
		logic found;
		logic out_free;
	} wpfm_stat_t;

	function automatic logic [7:0] fold(input logic [7:0] c, input logic cs);
		logic [7:0] r;
		r = c;
		if (!cs && c >= CH_LOW_A && c <= CH_LOW_Z) begin
			r = c - CASE_GAP;
		end
		return r;
	endfunction

endpackage

// File: rtl/wpfm_store.sv
// ----------------------------------------------------------------------------
// wpfm_store
// Character store: one write port, one registered read port; entries at or
// past the current length read as zero.
// ----------------------------------------------------------------------------
module wpfm_store #(
	parameter int DEPTH = 63,
	parameter int AW    = 6,
	parameter int LW    = 6,
	parameter int IW    = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [IW-1:0] ridx,
	input  logic [LW-1:0] len,
	output logic [7:0]    rdata
);

	logic [7:0]    mem [DEPTH];
	logic [7:0]    rd_q;
	logic          rv_q;
	logic          in_range;
	logic [AW-1:0] raddr;

	assign in_range = ridx < IW'(len);
	assign raddr    = in_range ? ridx[AW-1:0] : '0;
	assign rdata    = rv_q ? rd_q : 8'h00;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_q <= 1'b0;
		end else begin
			rv_q <= in_range;
		end
	end

endmodule

// File: rtl/wpfm_ctrl.sv
// ----------------------------------------------------------------------------
// wpfm_ctrl
// Match sequencer: walks the pattern and issues datapath commands.
// ----------------------------------------------------------------------------
module wpfm_ctrl
	import wpfm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  wpfm_stat_t st,
	output wpfm_cmd_t  cmd,
	output logic       idle
);

	typedef enum logic [20:0] {
		S_IDLE = 21'h000001,
		S_F0   = 21'h000002,
		S_F1   = 21'h000004,
		S_DEC  = 21'h000008,
		S_LIT  = 21'h000010,
		S_CLN  = 21'h000020,
		S_SS0  = 21'h000040,
		S_SS1  = 21'h000080,
		S_SSD  = 21'h000100,
		S_SK   = 21'h000200,
		S_SJ0  = 21'h000400,
		S_SJ1  = 21'h000800,
		S_CT   = 21'h001000,
		S_CA0  = 21'h002000,
		S_CA1  = 21'h004000,
		S_CD0  = 21'h008000,
		S_CD1  = 21'h010000,
		S_CB0  = 21'h020000,
		S_CB1  = 21'h040000,
		S_CE   = 21'h080000,
		S_DONE = 21'h100000
	} state_t;

	state_t state_q, state_d;
	logic   res_q, res_d;

	assign idle = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		res_d   = res_q;
		cmd     = '0;
		cmd.res = res_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.init = 1'b1;
					state_d  = S_F0;
				end
			end
			S_F0: begin
				if (st.p_end) begin
					res_d   = 1'b1;
					state_d = S_DONE;
				end else begin
					cmd.pa_sel = PA_P;
					state_d    = S_F1;
				end
			end
			S_F1: begin
				cmd.latch_c = 1'b1;
				cmd.pa_sel  = PA_P1;
				state_d     = S_DEC;
			end
			S_DEC: begin
				cmd.na_sel = NA_N;
				priority if (st.c_star) begin
					cmd.p_inc     = 2'd1;
					cmd.start_set = 1'b1;
					state_d       = S_SS0;
				end else if (st.c_qmark) begin
					cmd.p_inc = 2'd1;
					cmd.n_op  = N_INC;
					state_d   = S_F0;
				end else if (st.c_lbr && st.pd_lbr) begin
					cmd.p_inc = 2'd2;
					state_d   = S_LIT;
				end else if (st.c_lbr) begin
					cmd.p_inc = 2'd1;
					state_d   = S_CLN;
				end else begin
					cmd.p_inc = 2'd1;
					state_d   = S_LIT;
				end
			end
			S_LIT: begin
				if (st.lit_eq) begin
					cmd.n_op = N_INC;
					state_d  = S_F0;
				end else begin
					res_d   = 1'b0;
					state_d = S_DONE;
				end
			end
			S_CLN: begin
				cmd.latch_nc  = 1'b1;
				cmd.clr_found = 1'b1;
				state_d       = S_CT;
			end
			S_SS0: begin
				if (st.p_end) begin
					state_d = S_SSD;
				end else begin
					cmd.pa_sel = PA_P;
					state_d    = S_SS1;
				end
			end
			S_SS1: begin
				if (st.pd_star || st.pd_qmark) begin
					state_d = S_SSD;
				end else begin
					cmd.p_inc = 2'd1;
					state_d   = S_SS0;
				end
			end
			S_SSD: begin
				cmd.run_set = 1'b1;
				cmd.k_set   = 1'b1;
				priority if (st.run_zero) begin
					state_d = S_F0;
				end else if (st.run_over) begin
					res_d   = 1'b0;
					state_d = S_DONE;
				end else begin
					state_d = S_SK;
				end
			end
			S_SK: begin
				if (st.k_over) begin
					res_d   = 1'b0;
					state_d = S_DONE;
				end else begin
					cmd.j_clr = 1'b1;
					state_d   = S_SJ0;
				end
			end
			S_SJ0: begin
				if (st.j_done) begin
					cmd.n_op = N_KRUN;
					state_d  = S_F0;
				end else begin
					cmd.pa_sel = PA_SJ;
					cmd.na_sel = NA_KJ;
					state_d    = S_SJ1;
				end
			end
			S_SJ1: begin
				if (st.sj_eq) begin
					cmd.j_inc = 1'b1;
					state_d   = S_SJ0;
				end else begin
					cmd.k_inc = 1'b1;
					state_d   = S_SK;
				end
			end
			S_CT: begin
				if (st.p_end) begin
					state_d = S_CE;
				end else begin
					cmd.pa_sel = PA_P;
					state_d    = S_CA0;
				end
			end
			S_CA0: begin
				cmd.latch_a = 1'b1;
				cmd.pa_sel  = PA_P1;
				state_d     = S_CA1;
			end
			S_CA1: begin
				priority if (st.a_rbr && !st.pd_rbr) begin
					cmd.p_inc = 2'd1;
					state_d   = S_CE;
				end else if (st.a_rbr) begin
					cmd.p_inc = 2'd2;
					state_d   = S_CD0;
				end else begin
					cmd.p_inc = 2'd1;
					state_d   = S_CD0;
				end
			end
			S_CD0: begin
				cmd.pa_sel = PA_P;
				state_d    = S_CD1;
			end
			S_CD1: begin
				if (st.pd_dash && st.p1_ok) begin
					cmd.pa_sel = PA_P1;
					state_d    = S_CB0;
				end else begin
					cmd.fnd_single = 1'b1;
					state_d        = S_CT;
				end
			end
			S_CB0: begin
				cmd.latch_b = 1'b1;
				cmd.pa_sel  = PA_P2;
				state_d     = S_CB1;
			end
			S_CB1: begin
				priority if (st.b_rbr && !st.pd_rbr) begin
					cmd.fnd_single = 1'b1;
				end else if (st.b_rbr) begin
					cmd.fnd_range = 1'b1;
					cmd.p_inc     = 2'd3;
				end else begin
					cmd.fnd_range = 1'b1;
					cmd.p_inc     = 2'd2;
				end
				state_d = S_CT;
			end
			S_CE: begin
				if (st.found) begin
					cmd.n_op = N_INC;
					state_d  = S_F0;
				end else begin
					res_d   = 1'b0;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (st.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
		end
	end

endmodule

// File: rtl/wpfm_dp.sv
// ----------------------------------------------------------------------------
// wpfm_dp
// Match datapath: string stores, lengths, walk indices, compares and the
// result register.
// ----------------------------------------------------------------------------
module wpfm_dp
	import wpfm_pkg::*;
#(
	parameter int MAX_CHARS = 63
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              acc,
	input  logic [1:0]        action,
	input  logic [7:0]        ch,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_idx,
	input  logic              cfg_val,
	input  wpfm_cmd_t         cmd,
	output wpfm_stat_t        st,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              matched,
	output logic              truncated
);

	localparam int AW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
	localparam int LW = $clog2(MAX_CHARS + 1);
	localparam int IW = $clog2(2 * MAX_CHARS + 4);

	logic          cs_q, pm_q;
	logic [LW-1:0] plen_q, nlen_q;
	logic          ovf_q;
	logic [IW-1:0] p_q, n_q, start_q, run_q, k_q, j_q;
	logic [7:0]    c_q, a_q, b_q, nc_q;
	logic          found_q;
	logic          ov_q, om_q, ot_q;

	logic [IW-1:0] pidx, nidx, diff, plen_x, nlen_x;
	logic [7:0]    pd, nd, wch;
	logic          ld_pat, ld_name, pat_full, name_full;

	assign plen_x    = IW'(plen_q);
	assign nlen_x    = IW'(nlen_q);
	assign pat_full  = (plen_q == LW'(MAX_CHARS));
	assign name_full = (nlen_q == LW'(MAX_CHARS));
	assign ld_pat    = acc && (action == ACT_PAT) && (ch != 8'h00);
	assign ld_name   = acc && (action == ACT_NAME) && (ch != 8'h00);
	assign wch       = (pm_q && (ch == CH_BSLASH || ch == CH_COLON)) ? CH_SLASH : ch;

	always_comb begin
		unique case (cmd.pa_sel)
			PA_P:    pidx = p_q;
			PA_P1:   pidx = p_q + IW'(1);
			PA_P2:   pidx = p_q + IW'(2);
			PA_SJ:   pidx = start_q + j_q;
			default: pidx = p_q;
		endcase
		nidx = (cmd.na_sel == NA_KJ) ? (k_q + j_q) : n_q;
	end

	wpfm_store #(.DEPTH(MAX_CHARS), .AW(AW), .LW(LW), .IW(IW)) u_pat (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (ld_pat && !pat_full),
		.waddr (plen_q[AW-1:0]),
		.wdata (wch),
		.ridx  (pidx),
		.len   (plen_q),
		.rdata (pd)
	);

	wpfm_store #(.DEPTH(MAX_CHARS), .AW(AW), .LW(LW), .IW(IW)) u_name (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (ld_name && !name_full),
		.waddr (nlen_q[AW-1:0]),
		.wdata (wch),
		.ridx  (nidx),
		.len   (nlen_q),
		.rdata (nd)
	);

	assign diff = p_q - start_q;

	always_comb begin
		st.p_end    = (p_q >= plen_x);
		st.p1_ok    = ((p_q + IW'(1)) < plen_x);
		st.pd_star  = (pd == CH_STAR);
		st.pd_qmark = (pd == CH_QMARK);
		st.pd_lbr   = (pd == CH_LBR);
		st.pd_rbr   = (pd == CH_RBR);
		st.pd_dash  = (pd == CH_DASH);
		st.c_star   = (c_q == CH_STAR);
		st.c_qmark  = (c_q == CH_QMARK);
		st.c_lbr    = (c_q == CH_LBR);
		st.a_rbr    = (a_q == CH_RBR);
		st.b_rbr    = (b_q == CH_RBR);
		st.lit_eq   = (fold(c_q, cs_q) == fold(nd, cs_q));
		st.sj_eq    = (fold(pd, cs_q) == fold(nd, cs_q));
		st.run_zero = (diff == '0);
		st.run_over = (n_q > nlen_x) || (diff > (nlen_x - n_q));
		st.k_over   = ((k_q + run_q) > nlen_x);
		st.j_done   = (j_q == run_q);
		st.found    = found_q;
		st.out_free = !ov_q || out_ready;
	end

	assign out_valid = ov_q;
	assign matched   = om_q;
	assign truncated = ot_q;

	always_ff @(posedge clk) begin
		if (cmd.latch_c) c_q <= pd;
		if (cmd.latch_a) a_q <= pd;
		if (cmd.latch_b) b_q <= pd;
		if (cmd.latch_nc) nc_q <= fold(nd, cs_q);
		if (cmd.start_set) start_q <= p_q + IW'(1);
		if (cmd.run_set) run_q <= diff;
		if (cmd.k_set) begin
			k_q <= n_q;
		end else if (cmd.k_inc) begin
			k_q <= k_q + IW'(1);
		end
		if (cmd.j_clr) begin
			j_q <= '0;
		end else if (cmd.j_inc) begin
			j_q <= j_q + IW'(1);
		end
		if (cmd.finish) begin
			om_q <= cmd.res;
			ot_q <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_q    <= 1'b0;
			pm_q    <= 1'b1;
			plen_q  <= '0;
			nlen_q  <= '0;
			ovf_q   <= 1'b0;
			p_q     <= '0;
			n_q     <= '0;
			found_q <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			if (cfg_we && cfg_idx == REG_CASE_SENSITIVE) cs_q <= cfg_val;
			if (cfg_we && cfg_idx == REG_PATH_MODE) pm_q <= cfg_val;
			if (ld_pat) begin
				if (pat_full) begin
					ovf_q <= 1'b1;
				end else begin
					plen_q <= plen_q + LW'(1);
				end
			end
			if (ld_name) begin
				if (name_full) begin
					ovf_q <= 1'b1;
				end else begin
					nlen_q <= nlen_q + LW'(1);
				end
			end
			if (cmd.init) begin
				p_q <= '0;
			end else begin
				p_q <= p_q + IW'(cmd.p_inc);
			end
			if (cmd.init) begin
				n_q <= '0;
			end else begin
				unique case (cmd.n_op)
					N_HOLD:  n_q <= n_q;
					N_INC:   n_q <= n_q + IW'(1);
					N_KRUN:  n_q <= k_q + run_q;
					N_CLEAR: n_q <= '0;
					default: n_q <= n_q;
				endcase
			end
			if (cmd.clr_found) begin
				found_q <= 1'b0;
			end else if (cmd.fnd_single && fold(a_q, cs_q) == nc_q) begin
				found_q <= 1'b1;
			end else if (cmd.fnd_range && fold(a_q, cs_q) <= nc_q
					&& nc_q <= fold(b_q, cs_q)) begin
				found_q <= 1'b1;
			end
			if (cmd.finish) begin
				ov_q   <= 1'b1;
				plen_q <= '0;
				nlen_q <= '0;
				ovf_q  <= 1'b0;
			end else if (ov_q && out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/wildcard_path_filter_match_core.sv
// ----------------------------------------------------------------------------
// wildcard_path_filter_match_core
// Loads a wildcard pattern and a name one character per transfer, then
// matches them on an evaluate command.
// ----------------------------------------------------------------------------
// channel   direction  contents
// s_*       in         tuser: action; tdata: ch
// m_*       out        tdata: matched, truncated
// cfg_*     in         register index and write data
//
// Character loads are taken whenever the sequencer is idle. An evaluate holds
// s_tready low while the sequencer walks both stores: literal steps, '?', class
// elements and ranges, star runs, and a search over candidate positions that
// compares characters, then waits for the output register to be free. Reset
// leaves both strings empty; a pending result waits in the output register
// while further loads are taken.
module wildcard_path_filter_match_core
	import wpfm_pkg::*;
#(
	parameter int MAX_CHARS = 63
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // [7:0] ch
	input  logic [1:0]        s_tuser,   // [1:0] action
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,   // [0] matched, [1] truncated, rest zero
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic              cfg_data
);

	wpfm_cmd_t  cmd;
	wpfm_stat_t st;
	logic       idle, acc, matched, truncated;

	assign s_tready  = idle;
	assign acc       = s_tvalid && idle;
	assign cfg_ready = 1'b1;
	assign m_tdata   = {6'b0, truncated, matched};

	wpfm_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (acc && s_tuser == ACT_EVAL),
		.st    (st),
		.cmd   (cmd),
		.idle  (idle)
	);

	wpfm_dp #(.MAX_CHARS(MAX_CHARS)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.action   (s_tuser),
		.ch       (s_tdata),
		.cfg_we   (cfg_valid),
		.cfg_idx  (cfg_index),
		.cfg_val  (cfg_data),
		.cmd      (cmd),
		.st       (st),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.matched  (matched),
		.truncated(truncated)
	);

endmodule

// File: sim/tb_wildcard_path_filter_match_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wildcard_path_filter_match_core
// Streams pattern and name characters into the matcher, issues evaluate
// commands, and checks each match result against a behavioral glob predictor
// across case and path settings, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_wildcard_path_filter_match_core;
	import wpfm_pkg::*;

	localparam int CAP = 63;

	typedef struct packed {
		logic matched;
		logic truncated;
	} match_res_t;

	class match_board;
		logic [7:0] pat[CAP];
		logic [7:0] nam[CAP];
		int plen, nlen;
		bit ovf, cs, pm;
		match_res_t pending[$];
		int errors, checked;

		function new();
			plen = 0; nlen = 0; ovf = 0; cs = 0; pm = 1; errors = 0; checked = 0;
		endfunction

		function logic [7:0] pa(int i);
			return (i < plen) ? pat[i] : 8'd0;
		endfunction

		function logic [7:0] na(int i);
			return (i < nlen) ? nam[i] : 8'd0;
		endfunction

		function logic [7:0] fc(logic [7:0] c);
			if (!cs && c >= CH_LOW_A && c <= CH_LOW_Z) return c - CASE_GAP;
			return c;
		endfunction

		function bit lone_close(int q);
			return pa(q) == CH_RBR && pa(q + 1) != CH_RBR;
		endfunction

		function logic [7:0] elem(int q, output int w);
			if (pa(q) == CH_RBR && pa(q + 1) == CH_RBR) begin
				w = 2;
				return CH_RBR;
			end
			w = 1;
			return pa(q);
		endfunction

		function bit glob();
			int p, n, st, run, k, j, w, w2;
			logic [7:0] c, a, b, nc;
			bit hit, found;
			p = 0; n = 0;
			forever begin
				c = pa(p);
				if (p >= plen) return 1;
				if (c == CH_STAR) begin
					p++;
					st = p;
					while (p < plen && pa(p) != CH_STAR && pa(p) != CH_QMARK) p++;
					run = p - st;
					if (run == 0) continue;
					if (n > nlen || run > nlen - n) return 0;
					hit = 0;
					for (k = n; k + run <= nlen; k++) begin
						for (j = 0; j < run; j++)
							if (fc(pa(st + j)) != fc(na(k + j))) break;
						if (j == run) begin
							hit = 1;
							break;
						end
					end
					if (!hit) return 0;
					n = k + run;
				end else if (c == CH_QMARK) begin
					p++; n++;
				end else if (c == CH_LBR && pa(p + 1) == CH_LBR) begin
					if (na(n) != CH_LBR) return 0;
					p += 2; n++;
				end else if (c == CH_LBR) begin
					nc = fc(na(n));
					found = 0;
					p++;
					while (p < plen) begin
						if (lone_close(p)) begin
							p++;
							break;
						end
						a = elem(p, w);
						p += w;
						if (pa(p) == CH_DASH && p + 1 < plen && !lone_close(p + 1)) begin
							b = elem(p + 1, w2);
							p += 1 + w2;
							if (fc(a) <= nc && nc <= fc(b)) found = 1;
						end else if (fc(a) == nc) found = 1;
					end
					if (!found) return 0;
					n++;
				end else begin
					if (fc(c) != fc(na(n))) return 0;
					p++; n++;
				end
			end
		endfunction

		function void note_input(logic [1:0] act, logic [7:0] ch);
			logic [7:0] m;
			match_res_t r;
			m = (pm && (ch == CH_BSLASH || ch == CH_COLON)) ? CH_SLASH : ch;
			if (act == ACT_PAT && ch != 0) begin
				if (plen < CAP) pat[plen++] = m; else ovf = 1;
			end else if (act == ACT_NAME && ch != 0) begin
				if (nlen < CAP) nam[nlen++] = m; else ovf = 1;
			end else if (act == ACT_EVAL) begin
				r.matched = glob();
				r.truncated = ovf;
				pending.push_back(r);
				plen = 0; nlen = 0; ovf = 0;
			end
		endfunction

		function void check_result(logic [7:0] d);
			match_res_t e;
			checked++;
			if (pending.size() == 0) begin
				$error("unexpected result tdata=%h", d);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (d[0] !== e.matched) begin
				$error("matched: expected %0b actual %0b", e.matched, d[0]);
				errors++;
			end
			if (d[1] !== e.truncated) begin
				$error("truncated: expected %0b actual %0b", e.truncated, d[1]);
				errors++;
			end
			if (d[7:2] !== 6'd0) begin
				$error("padding: expected 0 actual %h", d[7:2]);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic s_tvalid = 0, m_tready = 0, cfg_valid = 0, cfg_data = 0;
	logic [7:0] s_tdata = 0;
	logic [1:0] s_tuser = 0;
	logic [CFG_IW-1:0] cfg_index = 0;
	logic s_tready, m_tvalid, cfg_ready;
	logic [7:0] m_tdata;
	match_board sb;
	bit hold_long = 0;
	int sent = 0;

	wildcard_path_filter_match_core dut (.*);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
		if (hold_long) m_tready <= 0;
		else m_tready <= ($urandom_range(0, 9) < 7) || (($urandom >> 4) % 3 == 0);
	end

	task automatic send(logic [1:0] act, logic [7:0] ch);
		s_tvalid <= 1;
		s_tuser <= act;
		s_tdata <= ch;
		do @(posedge clk); while (!s_tready);
		sb.note_input(act, ch);
		sent++;
		if ($urandom_range(0, 7) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic send_str(logic [1:0] act, string s);
		foreach (s[i]) send(act, s[i]);
	endtask

	task automatic write_reg(logic [CFG_IW-1:0] idx, logic v);
		s_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20000) @(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		if (idx == REG_CASE_SENSITIVE) sb.cs = v; else sb.pm = v;
		@(posedge clk);
	endtask

	task automatic rand_case(bit wellformed);
		int pl, nl;
		string alpha;
		alpha = "ab*?[]-\\:/AZaz";
		pl = ($urandom_range(0, 15) == 0) ? $urandom_range(50, 70) : $urandom_range(0, 8);
		nl = ($urandom_range(0, 15) == 0) ? $urandom_range(50, 70) : $urandom_range(0, 8);
		for (int i = 0; i < pl; i++)
			send(ACT_PAT, ($urandom_range(0, 3) == 0) ? 8'($urandom)
				: alpha[$urandom_range(0, alpha.len() - 1)]);
		for (int i = 0; i < nl; i++)
			send(ACT_NAME, ($urandom_range(0, 3) == 0) ? 8'($urandom)
				: alpha[$urandom_range(0, alpha.len() - 1)]);
		if (!wellformed) send(2'd3, 8'($urandom));
		send(ACT_EVAL, 8'($urandom));
	endtask

	initial begin
		#200000000;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_str(ACT_PAT, "*.txt"); send_str(ACT_NAME, "a.TXT"); send(ACT_EVAL, 8'hff);
		send_str(ACT_PAT, "a?[b-d]]]x"); send_str(ACT_NAME, "az]x"); send(ACT_EVAL, 0);
		send_str(ACT_PAT, "[[[]q"); send_str(ACT_NAME, "[q"); send(ACT_EVAL, 0);
		send_str(ACT_PAT, "c:\\[a-"); send(ACT_PAT, 0); send_str(ACT_NAME, "C//-");
		send(ACT_EVAL, 0);
		send_str(ACT_PAT, "*abc?"); send_str(ACT_NAME, "ab"); send(2'd3, 8'h41);
		send(ACT_EVAL, 0);
		write_reg(REG_CASE_SENSITIVE, 1);
		write_reg(REG_PATH_MODE, 0);
		for (int i = 0; i < 66; i++) send(ACT_NAME, 8'hff);
		send(ACT_PAT, 8'h80); send(ACT_EVAL, 0);
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(REG_CASE_SENSITIVE, ph[0]);
			write_reg(REG_PATH_MODE, ph[1]);
			if (ph == 2) fork
				begin
					hold_long = 1;
					repeat (3000) @(posedge clk);
					hold_long = 0;
				end
			join_none
			while (sent < 330 * (ph + 1)) rand_case($urandom_range(0, 9) != 0);
		end
		s_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20000) @(posedge clk);
		$display("covered %0d input transfers and %0d evaluate results", sent, sb.checked);
		$display("settings swept over both case and both path modes");
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule
